>>> hdl/assert_macros.svh
// Assertion macros used by the recognizer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a property holds at every clock edge outside reset.
`define AFRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("property check failed");
// Check that a condition never holds outside reset.
`define AFRC_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define AFRC_ASSERT(lbl, clk, rst_n, prop)
`define AFRC_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> hdl/afrc_pkg.sv
// Shared types and constants of the AT final result code recognizer.
package afrc_pkg;

    localparam int NUM_CODES = 8;
    localparam int CME_IDX   = 6;
    localparam int CMS_IDX   = 7;
    localparam int MAX_LEN   = 11;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [7:0] Z = 8'h00;

    // Result code texts, one row per code, padded with NUL.
    localparam logic [7:0] CODE_TEXT [NUM_CODES][MAX_LEN] = '{
        '{"O", "K", Z,   Z,   Z,   Z,   Z,   Z,   Z,   Z,   Z  },
        '{"E", "R", "R", "O", "R", Z,   Z,   Z,   Z,   Z,   Z  },
        '{"B", "U", "S", "Y", Z,   Z,   Z,   Z,   Z,   Z,   Z  },
        '{"N", "O", " ", "A", "N", "S", "W", "E", "R", Z,   Z  },
        '{"N", "O", " ", "C", "A", "R", "R", "I", "E", "R", Z  },
        '{"N", "O", " ", "D", "I", "A", "L", "T", "O", "N", "E"},
        '{"+", "C", "M", "E", " ", "E", "R", "R", "O", "R", Z  },
        '{"+", "C", "M", "S", " ", "E", "R", "R", "O", "R", Z  }
    };

    localparam logic [3:0] CODE_LEN [NUM_CODES] = '{
        4'd2, 4'd5, 4'd4, 4'd9, 4'd10, 4'd11, 4'd10, 4'd10
    };

    typedef enum logic [3:0] {
        KIND_OTHER      = 4'd0,
        KIND_OK         = 4'd1,
        KIND_ERROR      = 4'd2,
        KIND_BUSY       = 4'd3,
        KIND_NO_ANSWER  = 4'd4,
        KIND_NO_CARRIER = 4'd5,
        KIND_NO_DIALTON = 4'd6,
        KIND_CME        = 4'd7,
        KIND_CMS        = 4'd8
    } t_line_kind;

    typedef enum logic [2:0] {
        PH_NAME  = 3'd0,
        PH_COLON = 3'd1,
        PH_BLANK = 3'd2,
        PH_SIGN  = 3'd3,
        PH_DIGIT = 3'd4,
        PH_BAD   = 3'd5
    } t_code_phase;

    // One byte being processed this cycle.
    typedef struct packed {
        logic       valid;
        logic       eol;
        logic [7:0] rx_byte;
    } t_step;

    // Name matcher status toward the top level.
    typedef struct packed {
        t_line_kind kind;
        logic       colon_hit;
        logic       cme_alive;
    } t_match;

    // Code parser status toward the top level.
    typedef struct packed {
        t_code_phase phase;
        logic [31:0] code;
    } t_code;

endpackage

>>> hdl/afrc_name_match.sv
// Result code name matcher: candidate mask and line position.
module afrc_name_match (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  afrc_pkg::t_step  i_step,
    input  logic             i_name_phase,
    output afrc_pkg::t_match o_match
);

    logic [afrc_pkg::NUM_CODES-1:0] r_mask, n_mask;
    logic [3:0]                     r_pos, n_pos;
    logic [afrc_pkg::NUM_CODES-1:0] w_keep;
    logic                           w_colon;
    afrc_pkg::t_line_kind           w_kind;

    // Narrow the candidates by the current byte.
    always_comb begin
        w_keep  = '0;
        w_colon = 1'b0;
        for (int i = 0; i < afrc_pkg::NUM_CODES; i++) begin
            if (r_mask[i]) begin
                if (r_pos < afrc_pkg::CODE_LEN[i]) begin
                    if (i_step.rx_byte == afrc_pkg::CODE_TEXT[i][r_pos]) begin
                        w_keep[i] = 1'b1;
                    end
                end else if (r_pos == afrc_pkg::CODE_LEN[i] && i >= afrc_pkg::CME_IDX &&
                             i_step.rx_byte == afrc_pkg::CHAR_COLON) begin
                    w_keep[i] = 1'b1;
                    w_colon   = 1'b1;
                end
            end
        end
    end

    // Exact match of a plain result code at line end.
    always_comb begin
        w_kind = afrc_pkg::KIND_OTHER;
        for (int i = 0; i < afrc_pkg::CME_IDX; i++) begin
            if (r_mask[i] && r_pos == afrc_pkg::CODE_LEN[i]) begin
                w_kind = afrc_pkg::t_line_kind'(4'(i + 1));
            end
        end
    end

    always_comb begin
        n_mask = r_mask;
        n_pos  = r_pos;
        if (i_step.valid) begin
            if (i_step.eol) begin
                n_mask = '1;
                n_pos  = '0;
            end else begin
                if (i_name_phase) begin
                    n_mask = w_keep;
                end
                if (r_pos != 4'hF) begin
                    n_pos = r_pos + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '1;
            r_pos  <= '0;
        end else begin
            r_mask <= n_mask;
            r_pos  <= n_pos;
        end
    end

    assign o_match.kind      = w_kind;
    assign o_match.colon_hit = w_colon & i_name_phase;
    assign o_match.cme_alive = r_mask[afrc_pkg::CME_IDX];

endmodule

>>> hdl/afrc_code_parse.sv
// Error code parser: phase sequencer, decimal accumulator, saturation.
module afrc_code_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  afrc_pkg::t_step i_step,
    input  logic            i_colon_hit,
    output afrc_pkg::t_code o_code
);

    afrc_pkg::t_code_phase r_phase, n_phase, w_phase_adv;
    logic [31:0]           r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic                  r_ovf, n_ovf;

    logic        w_blank, w_sign, w_digit;
    logic [3:0]  w_digit_val;
    logic [35:0] w_prod;
    logic [31:0] w_code;

    assign w_blank = i_step.rx_byte == 8'h20 || i_step.rx_byte == 8'h09 ||
                     i_step.rx_byte == 8'h0B || i_step.rx_byte == 8'h0C;
    assign w_sign  = i_step.rx_byte == 8'h2B || i_step.rx_byte == 8'h2D;
    assign w_digit = i_step.rx_byte >= 8'h30 && i_step.rx_byte <= 8'h39;
    assign w_digit_val = i_step.rx_byte[3:0];

    // acc * 10 + digit, with room to see a carry past 32 bits.
    assign w_prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {32'd0, w_digit_val};

    // Next phase.
    always_comb begin
        w_phase_adv = r_phase;
        unique case (r_phase) inside
            afrc_pkg::PH_NAME: begin
                if (i_colon_hit) begin
                    w_phase_adv = afrc_pkg::PH_COLON;
                end
            end
            afrc_pkg::PH_COLON, afrc_pkg::PH_BLANK: begin
                if (w_blank) begin
                    w_phase_adv = afrc_pkg::PH_BLANK;
                end else if (w_sign) begin
                    w_phase_adv = afrc_pkg::PH_SIGN;
                end else if (w_digit) begin
                    w_phase_adv = afrc_pkg::PH_DIGIT;
                end else begin
                    w_phase_adv = afrc_pkg::PH_BAD;
                end
            end
            afrc_pkg::PH_SIGN, afrc_pkg::PH_DIGIT: begin
                w_phase_adv = w_digit ? afrc_pkg::PH_DIGIT : afrc_pkg::PH_BAD;
            end
            default: begin
                w_phase_adv = afrc_pkg::PH_BAD;
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        if (i_step.valid) begin
            n_phase = i_step.eol ? afrc_pkg::PH_NAME : w_phase_adv;
        end
    end

    // Accumulator, sign and overflow.
    always_comb begin
        n_acc = r_acc;
        n_neg = r_neg;
        n_ovf = r_ovf;
        if (i_step.valid) begin
            if (i_step.eol) begin
                n_acc = '0;
                n_neg = 1'b0;
                n_ovf = 1'b0;
            end else if (r_phase == afrc_pkg::PH_COLON || r_phase == afrc_pkg::PH_BLANK) begin
                if (w_sign) begin
                    n_neg = i_step.rx_byte == 8'h2D;
                end else if (w_digit) begin
                    n_acc = {28'd0, w_digit_val};
                end
            end else if (r_phase == afrc_pkg::PH_SIGN || r_phase == afrc_pkg::PH_DIGIT) begin
                if (w_digit) begin
                    if (|w_prod[35:32]) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = w_prod[31:0];
                    end
                end
            end
        end
    end

    // Saturated signed value of the digits seen so far.
    always_comb begin
        if (r_neg) begin
            w_code = (r_ovf || r_acc > 32'h8000_0000) ? 32'h8000_0000 : 32'd0 - r_acc;
        end else begin
            w_code = (r_ovf || r_acc[31]) ? 32'h7FFF_FFFF : r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= afrc_pkg::PH_NAME;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_ovf   <= n_ovf;
        end
    end

    assign o_code.phase = r_phase;
    assign o_code.code  = w_code;

endmodule

>>> hdl/at_final_result_code_recognizer_core.sv
// AT final result code recognizer: input register, line state, result register.
// A line-end byte is first held in the input register and, once it advances,
// is registered as a result in the result register.
// Throughput: one byte per cycle, set by the per-byte state update of the matcher
// and parser; only a stalled output result holds the input side.
// Reset: synchronous, active low; clears all line state and both handshake
// registers, leaving every candidate code alive.
`include "assert_macros.svh"

module at_final_result_code_recognizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_line_kind,
    output logic signed [31:0] o_error_code
);

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Line state kept here: the line holds at least one byte.
    logic        r_in_line, n_in_line;

    // Result register.
    logic        r_out_valid;
    logic [3:0]  r_out_kind;
    logic [31:0] r_out_code;

    logic             w_adv;
    afrc_pkg::t_step  w_step;
    afrc_pkg::t_match w_match;
    afrc_pkg::t_code  w_code;
    logic             w_emit;
    afrc_pkg::t_line_kind w_kind;
    logic [31:0]      w_err;

    // Advance the held byte whenever the result slot is free or being taken.
    assign w_adv   = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !w_adv;

    assign w_step.valid   = r_in_valid && w_adv;
    assign w_step.eol     = r_in_byte == afrc_pkg::CHAR_CR || r_in_byte == afrc_pkg::CHAR_LF;
    assign w_step.rx_byte = r_in_byte;

    afrc_name_match u_name_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_name_phase (w_code.phase == afrc_pkg::PH_NAME),
        .o_match      (w_match)
    );

    afrc_code_parse u_code_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_colon_hit (w_match.colon_hit),
        .o_code      (w_code)
    );

    // Classify the line at its end. Name phase: exact plain code match.
    // Right after the colon: empty code, so another line. Later: CME or CMS,
    // with a value only when digits ended the line.
    always_comb begin
        w_kind = afrc_pkg::KIND_OTHER;
        w_err  = '0;
        case (w_code.phase)
            afrc_pkg::PH_NAME: begin
                w_kind = w_match.kind;
            end
            afrc_pkg::PH_COLON: begin
                w_kind = afrc_pkg::KIND_OTHER;
            end
            default: begin
                w_kind = w_match.cme_alive ? afrc_pkg::KIND_CME : afrc_pkg::KIND_CMS;
                if (w_code.phase == afrc_pkg::PH_DIGIT) begin
                    w_err = w_code.code;
                end
            end
        endcase
    end

    // A run of line ends emits once: only a non-empty line produces a result.
    assign w_emit = w_step.valid && w_step.eol && r_in_line;

    always_comb begin
        n_in_line = r_in_line;
        if (w_step.valid) begin
            n_in_line = !w_step.eol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_line   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new byte whenever the input side is not stalled.
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            r_in_line <= n_in_line;
            // Fill the result slot on an emit, drop it once taken.
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_emit) begin
            r_out_kind <= w_kind;
            r_out_code <= w_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_line_kind  = r_out_kind;
    assign o_error_code = r_out_code;

    // A new result appears only after a line-end byte was processed.
    `AFRC_ASSERT(a_result_from_eol, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(w_step.valid && w_step.eol))
    // Only error lines carry a nonzero code.
    `AFRC_NEVER(a_code_only_on_error, i_clk, i_rst_n,
        r_out_valid && o_line_kind != afrc_pkg::KIND_CME &&
        o_line_kind != afrc_pkg::KIND_CMS && r_out_code != 32'd0)
    // An accepted byte is held in the input register on the next cycle.
    `AFRC_ASSERT(a_accept_loads, i_clk, i_rst_n,
        (i_valid && !o_stall) |=> r_in_valid)

endmodule
